[rtl/core/rv32_pkg.sv]
// Package of the RV32IM subset execute unit: opcodes, status codes, command
// and status structs shared by the controller and the datapath.
// Depends on nothing.
package rv32_pkg;

   localparam logic [6:0] OP_R   = 7'h33;
   localparam logic [6:0] OP_I   = 7'h13;
   localparam logic [6:0] OP_SYS = 7'h73;
   localparam logic [6:0] OP_BR  = 7'h63;
   localparam logic [6:0] OP_JAL = 7'h6F;
   localparam logic [6:0] OP_ST  = 7'h23;
   localparam logic [6:0] OP_LD  = 7'h03;
   localparam logic [6:0] OP_LUI = 7'h37;
   localparam logic [6:0] F7_ALT = 7'h20;
   localparam logic [6:0] F7_MUL = 7'h01;
   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_ECALL   = 2'd2;

   // Kind of work the decoded item needs.
   typedef enum logic [2:0] {
      K_ALU, K_MUL, K_DIV, K_LOAD, K_STORE, K_NONE
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the accepted item and read operands
      logic div_start;   // set up the divider
      logic div_step;    // one radix-2 division step
      logic mem_start;   // open a byte-serial memory access
      logic mem_step;    // one byte of a memory access
      logic commit;      // write register file, PC and result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     div_done;
      logic     mem_done;
   } stat_type;

endpackage

[rtl/core/rv32_ctrl.sv]
// Controller of the RV32IM subset execute unit: sequences capture, the
// iterative divider, the byte-serial memory access and commit.
// Depends on rv32_pkg.
module rv32_ctrl import rv32_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   output logic     out_valid,
   input  logic     out_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_DIV, S_MEM, S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      slot_free;

   // The result register frees as soon as the consumer takes it.
   assign slot_free = !valid_ff || out_ready;
   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !out_ready;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.kind)
               K_DIV: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
               K_LOAD, K_STORE: begin
                  cmd.mem_start = 1'b1;
                  state_in      = S_MEM;
               end
               default: state_in = S_COMMIT;
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = S_COMMIT;
         end
         S_MEM: begin
            cmd.mem_step = 1'b1;
            if (stat.mem_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[rtl/core/rv32_datapath.sv]
// Datapath of the RV32IM subset execute unit: register file, PC, data
// memory, ALU, multiplier, serial divider and the result register.
// Depends on rv32_pkg.
module rv32_datapath import rv32_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        in_action,
   input  logic [31:0] in_word,
   input  logic [15:0] in_addr,
   input  logic [7:0]  in_byte,
   output logic [1:0]  res_status,
   output logic [31:0] res_next_pc,
   output logic        res_written,
   output logic [4:0]  res_index,
   output logic [31:0] res_value,
   output logic [31:0] res_code,
   output logic [31:0] res_arg
);

   localparam int AW = $clog2(MEM_BYTES);

   // Architectural state.
   logic [31:0] regs_ff [32];
   logic [31:0] pc_ff;
   logic [7:0]  mem [MEM_BYTES];

   // Captured item and operands.
   logic        act_ff;
   logic [31:0] w_ff, a_ff, b_ff, x10_ff, x11_ff;
   logic [15:0] paddr_ff;
   logic [7:0]  pbyte_ff;

   // Decode fields.
   logic [6:0] op, f7;
   logic [2:0] f3;
   logic [4:0] rd;
   assign op = w_ff[6:0];
   assign rd = w_ff[11:7];
   assign f3 = w_ff[14:12];
   assign f7 = w_ff[31:25];

   logic [31:0] imm_i, imm_s, imm_b, imm_j;
   assign imm_i = {{20{w_ff[31]}}, w_ff[31:20]};
   assign imm_s = {{20{w_ff[31]}}, w_ff[31:25], w_ff[11:7]};
   assign imm_b = {{19{w_ff[31]}}, w_ff[31], w_ff[7], w_ff[30:25], w_ff[11:8], 1'b0};
   assign imm_j = {{11{w_ff[31]}}, w_ff[31], w_ff[19:12], w_ff[20], w_ff[30:21], 1'b0};

   // Legality and kind of the captured item.
   logic     legal;
   kind_type kind;
   always_comb begin
      legal = 1'b0;
      kind  = K_NONE;
      if (act_ff) begin
         legal = 1'b1;
      end else begin
         case (op)
            OP_R: begin
               if (f7 == F7_MUL) begin
                  legal = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd4) || (f3 == 3'd6);
                  kind  = (f3[2]) ? K_DIV : K_MUL;
               end else if (f7 == F7_ALT) begin
                  legal = (f3 == 3'd0) || (f3 == 3'd5);
                  kind  = K_ALU;
               end else if (f7 == 7'd0) begin
                  legal = (f3 != 3'd3);
                  kind  = K_ALU;
               end
            end
            OP_I: begin
               kind = K_ALU;
               case (f3)
                  3'd3:    legal = 1'b0;
                  3'd1:    legal = (f7 == 7'd0);
                  3'd5:    legal = (f7 == 7'd0) || (f7 == F7_ALT);
                  default: legal = 1'b1;
               endcase
            end
            OP_LD: begin
               legal = (f3 <= 3'd2);
               kind  = K_LOAD;
            end
            OP_ST: begin
               legal = (f3 <= 3'd2);
               kind  = K_STORE;
            end
            OP_BR:   legal = (f3 == 3'd0) || (f3 == 3'd1);
            OP_JAL:  legal = 1'b1;
            OP_LUI:  legal = 1'b1;
            OP_SYS:  legal = (w_ff == ECALL_WORD);
            default: legal = 1'b0;
         endcase
      end
      if (!legal) kind = K_NONE;
   end

   // Combinational ALU; the second operand is rs2 or the I immediate.
   logic [31:0] opb, alu_res;
   logic        alt;
   logic [4:0]  sh;
   assign opb = (op == OP_R) ? b_ff : imm_i;
   assign sh  = opb[4:0];
   assign alt = (op == OP_R) ? (f7 == F7_ALT) : w_ff[30];
   always_comb begin
      case (f3)
         3'd0:    alu_res = (op == OP_R && alt) ? a_ff - opb : a_ff + opb;
         3'd1:    alu_res = a_ff << sh;
         3'd2:    alu_res = {31'd0, $signed(a_ff) < $signed(opb)};
         3'd4:    alu_res = a_ff ^ opb;
         3'd5:    alu_res = alt ? 32'($signed(a_ff) >>> sh) : a_ff >> sh;
         3'd6:    alu_res = a_ff | opb;
         default: alu_res = a_ff & opb;
      endcase
   end

   // Multiplier: 32x32 signed product for MUL and MULH, registered.
   logic [63:0] prod_ff;
   always_ff @(posedge clock) begin
      prod_ff <= 64'($signed(a_ff) * $signed(b_ff));
   end

   // Radix-2 restoring divider over magnitudes, one quotient bit a cycle.
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic [5:0]  dcnt_ff;
   logic [32:0] trial;
   logic [31:0] ma, mb;
   assign ma    = a_ff[31] ? 32'(-a_ff) : a_ff;
   assign mb    = b_ff[31] ? 32'(-b_ff) : b_ff;
   assign trial = {dr_ff, dq_ff[31]} - {1'b0, dd_ff};
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff   <= ma;
         dr_ff   <= '0;
         dd_ff   <= mb;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 6'd1;
         if (!trial[32]) begin
            dr_ff <= trial[31:0];
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[30:0], dq_ff[31]};
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
      end
   end

   // Sign fixup and the special cases of division.
   logic [31:0] div_res;
   always_comb begin
      if (b_ff == 32'd0)
         div_res = f3[1] ? a_ff : 32'hFFFF_FFFF;
      else if (a_ff == 32'h8000_0000 && b_ff == 32'hFFFF_FFFF)
         div_res = f3[1] ? 32'd0 : 32'h8000_0000;
      else if (f3[1])
         div_res = a_ff[31] ? 32'(-dr_ff) : dr_ff;
      else
         div_res = (a_ff[31] ^ b_ff[31]) ? 32'(-dq_ff) : dq_ff;
   end

   // Byte-serial memory access, one byte a cycle, little-endian.
   logic [31:0] maddr_ff, ld_ff;
   logic [1:0]  mcnt_ff;
   logic [1:0]  mlast;
   logic [AW-1:0] mcur;
   logic [7:0]  rd_byte_ff;
   logic        rd_vld_ff;
   logic [1:0]  rd_pos_ff;
   assign mlast = (f3 == 3'd0) ? 2'd0 : (f3 == 3'd1) ? 2'd1 : 2'd3;
   assign mcur  = AW'(maddr_ff + 32'(mcnt_ff));

   always_ff @(posedge clock) begin
      rd_vld_ff <= cmd.mem_step && (op == OP_LD);
      if (cmd.mem_start) begin
         maddr_ff  <= a_ff + ((op == OP_ST) ? imm_s : imm_i);
         mcnt_ff   <= '0;
         ld_ff     <= '0;
      end else if (cmd.mem_step) begin
         mcnt_ff   <= mcnt_ff + 2'd1;
         rd_pos_ff <= mcnt_ff;
         if (op == OP_ST) mem[mcur] <= b_ff[8*mcnt_ff +: 8];
         else rd_byte_ff <= mem[mcur];
      end else if (cmd.commit && act_ff) begin
         mem[AW'(paddr_ff)] <= pbyte_ff;
      end
      if (rd_vld_ff && !cmd.mem_start) ld_ff[8*rd_pos_ff +: 8] <= rd_byte_ff;
   end

   // Loads are done only once the registered read of the last byte has landed.
   assign stat.mem_done = (op == OP_LD) ? (rd_vld_ff && rd_pos_ff == mlast)
                                        : (mcnt_ff == mlast);
   assign stat.div_done = (dcnt_ff == 6'd31);
   assign stat.kind     = kind;

   logic [31:0] load_val;
   always_comb begin
      case (f3)
         3'd0:    load_val = {{24{ld_ff[7]}}, ld_ff[7:0]};
         3'd1:    load_val = {{16{ld_ff[15]}}, ld_ff[15:0]};
         default: load_val = ld_ff;
      endcase
   end

   // Result of the item at commit.
   logic [31:0] val, npc;
   logic        wr;
   always_comb begin
      val = '0;
      wr  = 1'b0;
      npc = pc_ff + 32'd4;
      case (op)
         OP_R, OP_I: begin
            wr = 1'b1;
            case (kind)
               K_MUL:   val = f3[0] ? prod_ff[63:32] : prod_ff[31:0];
               K_DIV:   val = div_res;
               default: val = alu_res;
            endcase
         end
         OP_LD: begin
            wr  = 1'b1;
            val = load_val;
         end
         OP_BR: begin
            if ((a_ff == b_ff) ^ f3[0]) npc = pc_ff + imm_b;
         end
         OP_JAL: begin
            wr  = 1'b1;
            val = pc_ff + 32'd4;
            npc = pc_ff + imm_j;
         end
         OP_LUI: begin
            wr  = 1'b1;
            val = {w_ff[31:12], 12'd0};
         end
         default: ;
      endcase
      if (act_ff || !legal) begin
         npc = pc_ff;
         wr  = 1'b0;
      end
      if (rd == 5'd0 || !wr) begin
         wr  = 1'b0;
         val = '0;
      end
   end

   // Capture of the item and its operands.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= in_action;
         w_ff     <= in_word;
         paddr_ff <= in_addr;
         pbyte_ff <= in_byte;
         a_ff     <= regs_ff[in_word[19:15]];
         b_ff     <= regs_ff[in_word[24:20]];
         x10_ff   <= regs_ff[10];
         x11_ff   <= regs_ff[11];
      end
   end

   // Register file, PC and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= '0;
         pc_ff <= '0;
      end else if (cmd.commit) begin
         if (wr) regs_ff[rd] <= val;
         pc_ff <= npc;
      end
   end

   logic ecall;
   assign ecall = !act_ff && legal && (op == OP_SYS);
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_status  <= act_ff ? ST_OK : !legal ? ST_ILLEGAL : ecall ? ST_ECALL : ST_OK;
         res_next_pc <= npc;
         res_written <= wr;
         res_index   <= wr ? rd : 5'd0;
         res_value   <= val;
         res_code    <= ecall ? x10_ff : 32'd0;
         res_arg     <= ecall ? x11_ff : 32'd0;
      end
   end

endmodule

[rtl/core/rv32im_subset_execute_unit.sv]
// Top level of the RV32IM subset execute unit: joins controller and datapath.
// Depends on rv32_pkg, rv32_ctrl and rv32_datapath.
//
//  channel | direction | fields
//  req_    | in        | tuser: action; tdata: instruction_word, preload_address, preload_byte
//  rsp_    | out       | tdata: status, next_pc, reg_written, dest_index, dest_value,
//          |           |        ecall_code, ecall_argument
//
// An ALU, branch, jump, multiply or preload item passes through capture, decode and
// commit; loads and stores add a byte-serial access (one data memory port, one byte
// a cycle) and divide and remainder add the radix-2 divider before the commit.
// The next item can be taken in the cycle after the result is written.
// One item is in work at a time; a waiting result stalls only the commit.
// Reset is synchronous and clears registers and PC; data memory is not cleared.
module rv32im_subset_execute_unit import rv32_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [0:0]   req_tuser,   // action
   input  logic [55:0]  req_tdata,   // instruction_word, preload_address, preload_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata    // status, next_pc, reg_written, dest_index,
                                     // dest_value, ecall_code, ecall_argument
);

   cmd_type  cmd;
   stat_type stat;
   logic [1:0]  r_status;
   logic [31:0] r_npc, r_value, r_code, r_arg;
   logic        r_written;
   logic [4:0]  r_index;

   rv32_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .stat(stat), .cmd(cmd)
   );

   rv32_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_action(req_tuser[0]), .in_word(req_tdata[31:0]),
      .in_addr(req_tdata[47:32]), .in_byte(req_tdata[55:48]),
      .res_status(r_status), .res_next_pc(r_npc), .res_written(r_written),
      .res_index(r_index), .res_value(r_value), .res_code(r_code), .res_arg(r_arg)
   );

   assign rsp_tdata = {r_arg, r_code, r_value, r_index, r_written, r_npc, r_status};

   // A waiting result holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No new item is taken while a result from a commit is still due.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted during work");

   // A commit never overwrites a result that was not taken.
   a_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_tvalid || rsp_tready)
      else $error("result overwritten");

endmodule
